// ----- hdl/des_pkg.sv -----
// Shared types and constants for the double exponential smoother.
// Holds the sequencer state encoding, series phase codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package des_pkg;

  // Width of the level and trend estimates (sample units, Q32.0)
  localparam int EST_BITS = 32;

  // Configuration register indexes
  localparam logic REG_LEVEL_GAIN = 1'b0;
  localparam logic REG_TREND_GAIN = 1'b1;

  // Series phase codes
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_RUN    = 2'd2;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL_A = 8'b0000_0010,
    ST_MUL_B = 8'b0000_0100,
    ST_LVL   = 8'b0000_1000,
    ST_MUL_C = 8'b0001_0000,
    ST_MUL_D = 8'b0010_0000,
    ST_TRD   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } seq_state_t;

endpackage

`default_nettype wire

// ----- hdl/double_exponential_smoother.sv -----
// Holt double exponential smoother, top level.
// Depends on des_pkg (state encoding, phase codes, register indexes).
// One shared signed multiplier is stepped by a small sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Smooths a stream of signed samples and returns one smoothed level per sample.
// A sample with tuser set starts a new series; so does the first sample after
// reset. The first sample of a series is returned as the level, the second one
// seeds the trend with the difference of the two samples. From then on the
// level and trend follow the Holt update with gains alpha (register 0) and
// beta (register 1), both fixed point with GAIN_FRAC_BITS fraction bits where
// 1.0 is 2^GAIN_FRAC_BITS; larger values clamp to 1.0, both reset to 0.5.
// Each update rounds to nearest (ties up) and saturates to 32 bits; the output
// saturates to the sample range. A first or second sample of a series goes
// straight to the final step; a running sample sends its four products one
// per cycle through the single multiplier, with a rounding step after each
// pair, and then a final step that loads the output register once it is free.
// The input takes the next transfer once the result is in the output register,
// so a result waiting on out_tready stalls only the following sample's
// completion, not its transfer.
module double_exponential_smoother
  import des_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // configuration write port
  input  wire                            cfg_we,
  input  wire                            cfg_index,
  input  wire  [GAIN_FRAC_BITS:0]        cfg_data,
  // sample stream
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,  // [SAMPLE_BITS-1:0] sample
  input  wire                            in_tuser,  // series_start
  // smoothed level stream
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata  // [SAMPLE_BITS-1:0] smoothed_level
);

  localparam int GW = GAIN_FRAC_BITS + 1;      // gain register width
  localparam int AW = GAIN_FRAC_BITS + 2;      // multiplier gain operand, signed
  localparam int BW = EST_BITS + 1;            // multiplier value operand, signed
  localparam int PW = AW + BW;                 // product width
  localparam int SW = PW + 1;                  // sum of two products
  localparam int RW = SW - GAIN_FRAC_BITS;     // after the rounding shift
  localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [GW-1:0] GAIN_ONE  = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [GW-1:0] GAIN_HALF = {2'b01, {(GAIN_FRAC_BITS-1){1'b0}}};
  localparam logic [SW-1:0] RND_HALF  = SW'(GAIN_HALF);

  // Saturate a wide signed value to the estimate width.
  function automatic logic signed [EST_BITS-1:0] sat_est(input logic signed [RW-1:0] v);
    logic [RW-EST_BITS:0] upper;
    upper = v[RW-1:EST_BITS-1];
    if (&upper || ~|upper) begin
      return v[EST_BITS-1:0];
    end else if (v[RW-1]) begin
      return {1'b1, {(EST_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(EST_BITS-1){1'b1}}};
    end
  endfunction

  // Saturate an estimate to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [EST_BITS-1:0] v
  );
    logic [EST_BITS-SAMPLE_BITS:0] upper;
    upper = v[EST_BITS-1:SAMPLE_BITS-1];
    if (&upper || ~|upper) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[EST_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  // Clamp a written gain to 1.0.
  function automatic logic [GW-1:0] clamp_gain(input logic [GW-1:0] g);
    return (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  seq_state_t                  state_r, state_nxt;
  logic [1:0]                  phase_r, phase_nxt;
  logic [GW-1:0]               alpha_r, beta_r;
  logic signed [EST_BITS-1:0]  level_r, level_nxt;
  logic signed [EST_BITS-1:0]  trend_r, trend_nxt;
  logic signed [EST_BITS-1:0]  prev_r, prev_nxt;     // level before this update
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;         // held sample
  logic signed [PW-1:0]        prod_r, prod_nxt;     // multiplier output register
  logic signed [PW-1:0]        acc_r, acc_nxt;       // first product of a pair
  logic                        out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_level_r, out_level_nxt;

  // ---------------------------------------------------------------------------
  // Shared multiplier and rounding
  // ---------------------------------------------------------------------------
  logic [GW-1:0]              mul_gain;
  logic signed [AW-1:0]       mul_a;
  logic signed [BW-1:0]       mul_b;
  logic signed [SW-1:0]       pair_sum;
  logic signed [EST_BITS-1:0] pair_rnd;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic signed [BW-1:0]       first_diff;
  logic                       in_xfer;
  logic                       out_xfer;

  assign in_sample = in_tdata[SAMPLE_BITS-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;

  // Pick the operands for the current step of the update.
  always_comb begin
    mul_gain = alpha_r;
    mul_b    = BW'(x_r);
    case (state_r)
      ST_MUL_A: begin
        mul_gain = alpha_r;
        mul_b    = BW'(x_r);
      end
      ST_MUL_B: begin
        mul_gain = GAIN_ONE - alpha_r;
        mul_b    = BW'(level_r) + BW'(trend_r);
      end
      ST_MUL_C: begin
        mul_gain = beta_r;
        mul_b    = BW'(level_r) - BW'(prev_r);
      end
      ST_MUL_D: begin
        mul_gain = GAIN_ONE - beta_r;
        mul_b    = BW'(trend_r);
      end
      default: begin
        mul_gain = alpha_r;
        mul_b    = BW'(x_r);
      end
    endcase
  end

  assign mul_a    = $signed({1'b0, mul_gain});
  assign pair_sum = SW'(acc_r) + SW'(prod_r) + $signed(RND_HALF);
  // floor after adding half: round to nearest, ties toward plus infinity
  assign pair_rnd = sat_est(pair_sum[SW-1:GAIN_FRAC_BITS]);

  // Seed trend for the second sample of a series.
  assign first_diff = BW'(in_sample) - BW'(level_r);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    level_nxt     = level_r;
    trend_nxt     = trend_r;
    prev_nxt      = prev_r;
    x_nxt         = x_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;

    // drop the result once the consumer takes it
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          x_nxt    = in_sample;
          prev_nxt = level_r;
          if (in_tuser || phase_r == PH_FIRST) begin
            // start of a series: level takes the sample, trend clears
            level_nxt = EST_BITS'(in_sample);
            trend_nxt = '0;
            phase_nxt = PH_SECOND;
            state_nxt = ST_FIN;
          end else if (phase_r == PH_SECOND) begin
            trend_nxt = sat_est(RW'(first_diff));
            level_nxt = EST_BITS'(in_sample);
            phase_nxt = PH_RUN;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_MUL_A;
          end
        end
      end
      ST_MUL_A: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        acc_nxt   = prod_r;
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_LVL;
      end
      ST_LVL: begin
        level_nxt = pair_rnd;
        state_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        acc_nxt   = prod_r;
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_TRD;
      end
      ST_TRD: begin
        trend_nxt = pair_rnd;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = sat_smp(level_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FIRST;
      level_r     <= '0;
      trend_r     <= '0;
      out_valid_r <= 1'b0;
      alpha_r     <= GAIN_HALF;
      beta_r      <= GAIN_HALF;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      level_r     <= level_nxt;
      trend_r     <= trend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_LEVEL_GAIN: alpha_r <= clamp_gain(cfg_data);
          REG_TREND_GAIN: beta_r  <= clamp_gain(cfg_data);
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    prev_r      <= prev_nxt;
    x_r         <= x_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    out_level_r <= out_level_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DW'($unsigned(out_level_r));

endmodule

`default_nettype wire

// ----- verif/double_exponential_smoother_tb.sv -----
// Self-checking testbench for the Holt double exponential smoother.
// Drives sample transfers and gain writes, predicts every smoothed level, and checks it.
// Depends on des_pkg and double_exponential_smoother; needs nothing else.
`timescale 1ns / 1ps

module double_exponential_smoother_tb;
  import des_pkg::*;

  localparam int SAMPLE_W   = 24;
  localparam int FRAC_W     = 16;
  localparam int GAIN_W     = FRAC_W + 1;
  localparam int TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;
  localparam longint UNITY  = longint'(1) << FRAC_W;
  localparam longint SMP_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SMP_MIN = -(longint'(1) << (SAMPLE_W - 1));
  localparam longint EST_MAX = (longint'(1) << (EST_BITS - 1)) - 1;
  localparam longint EST_MIN = -(longint'(1) << (EST_BITS - 1));
  // Settling time after the last pending level, well past the longest transfer-to-result latency.
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 100;
  localparam longint RUN_LIMIT_NS = 2_000_000;

  // Every input starts at a known value.
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic                  cfg_index  = 1'b0;
  logic [GAIN_W-1:0]     cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata   = '0;  // [23:0] sample
  logic                  in_tuser   = 1'b0;  // series_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;  // [23:0] smoothed_level

  // Shadow of the smoother: gains, estimates and series phase.
  logic [GAIN_W-1:0]          alpha_q  = GAIN_W'(UNITY >> 1);
  logic [GAIN_W-1:0]          beta_q   = GAIN_W'(UNITY >> 1);
  logic signed [EST_BITS-1:0] level_q  = '0;
  logic signed [EST_BITS-1:0] trend_q  = '0;
  logic [1:0]                 phase_q  = PH_FIRST;

  logic [SAMPLE_W-1:0] pending_levels [$];
  int                  mismatch_count = 0;
  int                  burst_left     = 0;
  int                  ready_hold     = 0;

  // One directed row: sample, start flag, and a hand-written level where obvious.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                start;
    logic                known;
    logic [SAMPLE_W-1:0] level;
  } smoke_row_t;

  localparam int SMOKE_ROWS = 24;
  smoke_row_t smoke_rows [0:SMOKE_ROWS-1] = '{
    // no start flag after reset still opens a series
    '{24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF},
    // second sample: level follows it, trend spans the full range
    '{24'h800000, 1'b0, 1'b1, 24'h800000},
    '{24'h000000, 1'b0, 1'b0, 24'h000000},
    '{24'h000000, 1'b0, 1'b0, 24'h000000},
    // restart while running
    '{24'h00007B, 1'b1, 1'b1, 24'h00007B},
    // restart while waiting for the second sample
    '{24'hFFFFFF, 1'b1, 1'b1, 24'hFFFFFF},
    '{24'h000005, 1'b0, 1'b1, 24'h000005},
    '{24'h000005, 1'b0, 1'b0, 24'h000000},
    '{24'h555555, 1'b0, 1'b0, 24'h000000},
    '{24'hAAAAAA, 1'b0, 1'b0, 24'h000000},
    '{24'h800000, 1'b1, 1'b1, 24'h800000},
    '{24'h800000, 1'b0, 1'b1, 24'h800000},
    '{24'h800000, 1'b0, 1'b0, 24'h000000},
    '{24'h7FFFFF, 1'b1, 1'b1, 24'h7FFFFF},
    '{24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF},
    '{24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
    // steep rising trend pushes the level past the sample range
    '{24'h000000, 1'b1, 1'b1, 24'h000000},
    '{24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF},
    '{24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
    '{24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
    '{24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
    '{24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
    '{24'h000001, 1'b1, 1'b1, 24'h000001},
    '{24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF}
  };

  double_exponential_smoother #(
    .SAMPLE_BITS    (SAMPLE_W),
    .GAIN_FRAC_BITS (FRAC_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Divide by 2^FRAC_W, round to nearest with ties toward plus infinity.
  function automatic longint round_frac(input longint v);
    return (v + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic logic signed [EST_BITS-1:0] sat_estimate(input longint v);
    if (v > EST_MAX) return EST_BITS'(EST_MAX);
    if (v < EST_MIN) return EST_BITS'(EST_MIN);
    return EST_BITS'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] fit_sample(input longint v);
    if (v > SMP_MAX) return SAMPLE_W'(SMP_MAX);
    if (v < SMP_MIN) return SAMPLE_W'(SMP_MIN);
    return SAMPLE_W'(v);
  endfunction

  // Advance the shadow smoother by one sample and return the level it outputs.
  function automatic logic [SAMPLE_W-1:0] smooth_sample(input logic [SAMPLE_W-1:0] raw,
                                                        input logic start);
    longint x, prev, proj, acc, ga, gb;
    x  = longint'($signed(raw));
    ga = alpha_q;
    gb = beta_q;
    if (start || phase_q == PH_FIRST) begin
      level_q = EST_BITS'(x);
      trend_q = '0;
      phase_q = PH_SECOND;
    end else if (phase_q == PH_SECOND) begin
      trend_q = sat_estimate(x - level_q);
      level_q = EST_BITS'(x);
      phase_q = PH_RUN;
    end else begin
      prev    = level_q;
      proj    = prev + trend_q;
      acc     = ga * x + (UNITY - ga) * proj;
      level_q = sat_estimate(round_frac(acc));
      // trend uses the stored, already saturated level
      acc     = gb * (level_q - prev) + (UNITY - gb) * trend_q;
      trend_q = sat_estimate(round_frac(acc));
    end
    return fit_sample(level_q);
  endfunction

  // Hand one sample to the block. Bursts of random length with random gaps;
  // a gap of zero leaves tvalid high so a transfer follows as soon as the block is ready.
  // Returns at the edge where the transfer happened.
  task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input logic start,
                             input logic known, input logic [SAMPLE_W-1:0] known_level);
    int gap;
    logic [SAMPLE_W-1:0] want;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(raw);
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    want = smooth_sample(raw, start);
    if (known) want = known_level;
    pending_levels.push_back(want);
    burst_left--;
  endtask

  // Drop tvalid, wait for every pending level, then let the pipeline settle.
  task automatic drain_levels();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both gains on consecutive edges; mirror the clamp to 1.0.
  task automatic write_gains(input logic [GAIN_W-1:0] alpha, input logic [GAIN_W-1:0] beta);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LEVEL_GAIN;
    cfg_data  <= alpha;
    @(posedge clk);
    cfg_index <= REG_TREND_GAIN;
    cfg_data  <= beta;
    @(posedge clk);
    cfg_we    <= 1'b0;
    alpha_q = (alpha > UNITY) ? GAIN_W'(UNITY) : alpha;
    beta_q  = (beta > UNITY) ? GAIN_W'(UNITY) : beta;
  endtask

  // Receiver: long stalls, long stretches of steady readiness, or coin flips.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_tready <= 1'b0;
          ready_hold <= $urandom_range(1, 30);
        end
        1: begin
          out_tready <= 1'b1;
          ready_hold <= $urandom_range(20, 60);
        end
        default: begin
          out_tready <= 1'($urandom_range(0, 1));
        end
      endcase
    end
  end

  // Check every result transfer against the oldest pending level.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t ns: smoothed level with nothing pending, expected none, got %0d",
                 $time, $signed(out_tdata[SAMPLE_W-1:0]));
        mismatch_count <= mismatch_count + 1;
      end else begin
        if (out_tdata[SAMPLE_W-1:0] !== pending_levels[0]) begin
          $display("%0t ns: smoothed level mismatch, expected %0d, got %0d", $time,
                   $signed(pending_levels[0]), $signed(out_tdata[SAMPLE_W-1:0]));
          mismatch_count <= mismatch_count + 1;
        end
        void'(pending_levels.pop_front());
      end
    end
  end

  initial begin
    int p, k, len, shape, sent;
    longint base, slope, lim, v;
    logic [GAIN_W-1:0] ga, gb;
    logic start, long_run, low_first;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset gains of one half.
    for (k = 0; k < SMOKE_ROWS; k++) begin
      send_sample(smoke_rows[k].sample, smoke_rows[k].start,
                  smoke_rows[k].known, smoke_rows[k].level);
    end
    drain_levels();

    // Random part: one gain setting per phase, extremes first.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin ga = '0;                  gb = '0;                  end
        1: begin ga = GAIN_W'(UNITY);      gb = GAIN_W'(UNITY);      end
        2: begin ga = '1;                  gb = GAIN_W'(UNITY + 1);  end
        3: begin ga = GAIN_W'(1);          gb = GAIN_W'(UNITY - 1);  end
        4: begin ga = GAIN_W'(UNITY - 1);  gb = GAIN_W'(1);          end
        5: begin ga = '0;                  gb = GAIN_W'(UNITY);      end
        default: begin
          ga = GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1));
          gb = GAIN_W'($urandom_range(0, 32'(2 * UNITY)));
        end
      endcase
      write_gains(ga, gb);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Mostly short series; now and then a long one that starts with a
        // full-scale step so a weak level gain drives the estimates to saturation.
        long_run  = ($urandom_range(0, 9) == 0);
        len       = long_run ? $urandom_range(150, 300) : $urandom_range(1, 40);
        shape     = $urandom_range(0, 2);
        low_first = 1'($urandom_range(0, 1));
        base      = longint'($urandom_range(0, 24'hFFFFFF)) + SMP_MIN;
        lim       = longint'(1) << $urandom_range(0, 17);
        slope     = longint'($urandom_range(0, 32'(2 * lim))) - lim;
        for (k = 0; k < len; k++) begin
          // usually flag the series head; occasionally leave it off, or
          // throw a stray restart into the middle
          if (k == 0) start = ($urandom_range(0, 7) != 0);
          else        start = ($urandom_range(0, 49) == 0);
          if (long_run && k < 2) begin
            v = ((k == 0) == low_first) ? SMP_MIN : SMP_MAX;
          end else begin
            case (shape)
              0: v = longint'($urandom_range(0, 24'hFFFFFF)) + SMP_MIN;
              1: v = base + k * slope + longint'($urandom_range(0, 64)) - 32;
              default: begin
                case ($urandom_range(0, 3))
                  0: v = SMP_MIN;
                  1: v = SMP_MAX;
                  2: v = 0;
                  default: v = -1;
                endcase
              end
            endcase
          end
          send_sample(fit_sample(v), start, 1'b0, '0);
        end
        sent += len;
      end
      drain_levels();
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
